### hdl/bfgl_pkg.sv
`timescale 1ns / 1ps

package bfgl_pkg;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_START_CHAR    = 3'd0;
  localparam logic [2:0] REG_GLYPH_COLUMNS = 3'd1;
  localparam logic [2:0] REG_CELL_WIDTH    = 3'd2;
  localparam logic [2:0] REG_CELL_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_FONT_HEIGHT   = 3'd4;

  typedef enum logic [2:0] {
    K_BEGIN,
    K_LOAD,
    K_NEWLINE,
    K_GLYPH,
    K_NOP
  } kind_e;

  typedef struct packed {
    logic [7:0] start_char;
    logic [8:0] glyph_columns;
    logic [7:0] cell_width;
    logic [7:0] cell_height;
    logic [7:0] font_height;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        code;
    logic [7:0]        slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]        width_value;
  } cmd_t;

  typedef struct packed {
    logic        quad_valid;
    logic [15:0] left_x;
    logic [15:0] top_y;
    logic [15:0] right_x;
    logic [15:0] bottom_y;
    logic [15:0] tex_left;
    logic [15:0] tex_top;
    logic [15:0] tex_right;
    logic [15:0] tex_bottom;
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
  } res_t;

endpackage

### hdl/bfgl_front.sv
`timescale 1ns / 1ps

module bfgl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         operation_i,
  input  logic [7:0]         char_code_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [7:0]         width_value_i,
  input  logic [7:0]         start_char_i,
  output bfgl_pkg::cmd_t     head_o,
  output logic               head_valid_o,
  input  logic               head_pop_i
);
  import bfgl_pkg::*;

  cmd_t       cmd;
  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  always_comb begin
    cmd.code        = char_code_i;
    cmd.slot        = char_code_i - start_char_i;
    cmd.pos_x       = pos_x_i;
    cmd.pos_y       = pos_y_i;
    cmd.width_value = width_value_i;
    unique case (operation_i)
      OP_BEGIN: cmd.kind = K_BEGIN;
      OP_LOAD:  cmd.kind = K_LOAD;
      OP_DRAW:  cmd.kind = (char_code_i == NEWLINE_CODE) ? K_NEWLINE : K_GLYPH;
      default:  cmd.kind = K_NOP;
    endcase
  end

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = head_pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd;
  end

endmodule

### hdl/bfgl_back.sv
`timescale 1ns / 1ps

module bfgl_back #(
  parameter int GLYPH_COUNT = 256,
  parameter int COORD_BITS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bfgl_pkg::cfg_t cfg_i,
  input  bfgl_pkg::cmd_t head_i,
  input  logic           head_valid_i,
  output logic           head_pop_o,
  output bfgl_pkg::res_t res_o,
  output logic           res_valid_o,
  input  logic           res_pop_i
);
  import bfgl_pkg::*;

  localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int CW    = COORD_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_SUM} state_e;

  state_e          state_q;
  logic [2:0]      cnt_q;
  logic [CW-1:0]   cursor_x_q, cursor_y_q, line_q;
  logic [CW-1:0]   nxt_cx, nxt_cy, nxt_line;
  logic            res_valid_q, res_load, out_free;
  res_t            res_q, res_d;

  logic [7:0]      table_q [GLYPH_COUNT];
  logic [7:0]      rd_q;
  logic            in_range_q, head_in_range;
  logic [7:0]      width;

  logic [8:0]      cols, div_sh, div_sub;
  logic            div_ge;
  logic [7:0]      div_rem_q, div_quo_q;
  logic [15:0]     tl_q, tt_q;
  logic [16:0]     tr_sum, tb_sum;
  logic [CW-1:0]   right_x, bottom_y;

  assign out_free      = !res_valid_q || res_pop_i;
  assign head_in_range = {1'b0, head_i.code} < 9'(GLYPH_COUNT);
  assign width         = in_range_q ? rd_q : 8'd0;

  always_comb begin
    priority if (cfg_i.glyph_columns == 9'd0)   cols = 9'd1;
    else if (cfg_i.glyph_columns > 9'd256)      cols = 9'd256;
    else                                        cols = cfg_i.glyph_columns;
    // one quotient bit per cycle
    div_sh  = {div_rem_q, div_quo_q[7]};
    div_ge  = (div_sh >= cols);
    div_sub = div_sh - cols;
  end

  assign head_pop_o = (state_q == ST_IDLE) && head_valid_i &&
                      ((head_i.kind == K_GLYPH) || out_free);

  always_comb begin
    nxt_cx   = cursor_x_q;
    nxt_cy   = cursor_y_q;
    nxt_line = line_q;
    res_d    = '0;
    res_load = 1'b0;
    tr_sum   = {1'b0, tl_q} + 17'(width);
    tb_sum   = {1'b0, tt_q} + 17'(cfg_i.cell_height);
    right_x  = cursor_x_q + CW'(width);
    bottom_y = cursor_y_q + CW'(cfg_i.cell_height);
    if (state_q == ST_IDLE && head_pop_o && head_i.kind != K_GLYPH) begin
      res_load = 1'b1;
      unique case (head_i.kind)
        K_BEGIN: begin
          nxt_cx   = CW'(head_i.pos_x);
          nxt_cy   = CW'(head_i.pos_y);
          nxt_line = CW'(head_i.pos_x);
        end
        K_NEWLINE: begin
          nxt_cy = cursor_y_q + CW'(cfg_i.font_height);
          nxt_cx = line_q;
        end
        default: ;
      endcase
    end
    if (state_q == ST_SUM && out_free) begin
      res_load         = 1'b1;
      nxt_cx           = right_x;
      res_d.quad_valid = 1'b1;
      res_d.left_x     = 16'(cursor_x_q);
      res_d.top_y      = 16'(cursor_y_q);
      res_d.right_x    = 16'(right_x);
      res_d.bottom_y   = 16'(bottom_y);
      res_d.tex_left   = tl_q;
      res_d.tex_top    = tt_q;
      res_d.tex_right  = tr_sum[16] ? 16'hFFFF : tr_sum[15:0];
      res_d.tex_bottom = tb_sum[16] ? 16'hFFFF : tb_sum[15:0];
    end
    res_d.cursor_x = 16'(nxt_cx);
    res_d.cursor_y = 16'(nxt_cy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 3'd0;
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      line_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_load) begin
        cursor_x_q  <= nxt_cx;
        cursor_y_q  <= nxt_cy;
        line_q      <= nxt_line;
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (head_pop_o && head_i.kind == K_GLYPH) begin
            state_q <= ST_DIV;
            cnt_q   <= 3'd0;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7) state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_SUM;
        ST_SUM: if (out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res_d;
    if (state_q == ST_IDLE && head_pop_o) begin
      if (head_i.kind == K_LOAD && head_in_range)
        table_q[head_i.code[IDX_W-1:0]] <= head_i.width_value;
      rd_q       <= table_q[head_i.code[IDX_W-1:0]];
      in_range_q <= head_in_range;
      div_rem_q  <= 8'd0;
      div_quo_q  <= head_i.slot;
    end
    if (state_q == ST_DIV) begin
      div_rem_q <= div_ge ? div_sub[7:0] : div_sh[7:0];
      div_quo_q <= {div_quo_q[6:0], div_ge};
    end
    if (state_q == ST_MUL) begin
      tl_q <= 16'(div_rem_q) * 16'(cfg_i.cell_width);
      tt_q <= 16'(div_quo_q) * 16'(cfg_i.cell_height);
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

### hdl/bitmap_font_glyph_layout.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Transfer when
// input     in         push / full        push && !full
// result    out        empty / pop        pop && !empty
// config    in         psel/penable/...   psel && penable && pwrite (pready tied high)
//
// A glyph goes from queue head to result through a fetch, 8 divider steps
// (one quotient bit a cycle), a multiply and a sum; other items load the result
// directly. The sustained rate is set by the restoring divider in the back end.
// Reset clears configuration to defaults, cursor and queues; the width
// table is left as is. A two-entry queue lets input run ahead while a result
// waits for pop; a full result register holds non-glyph items and the glyph sum.
module bitmap_font_glyph_layout #(
  parameter int GLYPH_COUNT = 256,
  parameter int COORD_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 operation_i,
  input  logic [7:0]                 char_code_i,
  input  logic signed [15:0]         pos_x_i,
  input  logic signed [15:0]         pos_y_i,
  input  logic [7:0]                 width_value_i,
  output logic                       empty,
  input  logic                       pop,
  output logic                       quad_valid_o,
  output logic signed [15:0]         left_x_o,
  output logic signed [15:0]         top_y_o,
  output logic signed [15:0]         right_x_o,
  output logic signed [15:0]         bottom_y_o,
  output logic [15:0]                tex_left_o,
  output logic [15:0]                tex_top_o,
  output logic [15:0]                tex_right_o,
  output logic [15:0]                tex_bottom_o,
  output logic signed [15:0]         cursor_x_out_o,
  output logic signed [15:0]         cursor_y_out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bfgl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import bfgl_pkg::*;

  cfg_t       cfg_q;
  cmd_t       head;
  logic       head_valid, head_pop, res_valid;
  res_t       res;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_char    <= 8'd32;
      cfg_q.glyph_columns <= 9'd16;
      cfg_q.cell_width    <= 8'd16;
      cfg_q.cell_height   <= 8'd16;
      cfg_q.font_height   <= 8'd16;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_START_CHAR:    cfg_q.start_char    <= pwdata[7:0];
        REG_GLYPH_COLUMNS: cfg_q.glyph_columns <= pwdata[8:0];
        REG_CELL_WIDTH:    cfg_q.cell_width    <= pwdata[7:0];
        REG_CELL_HEIGHT:   cfg_q.cell_height   <= pwdata[7:0];
        REG_FONT_HEIGHT:   cfg_q.font_height   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_CHAR:    prdata = 32'(cfg_q.start_char);
      REG_GLYPH_COLUMNS: prdata = 32'(cfg_q.glyph_columns);
      REG_CELL_WIDTH:    prdata = 32'(cfg_q.cell_width);
      REG_CELL_HEIGHT:   prdata = 32'(cfg_q.cell_height);
      REG_FONT_HEIGHT:   prdata = 32'(cfg_q.font_height);
      default:           prdata = 32'd0;
    endcase
  end

  bfgl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .operation_i   (operation_i),
    .char_code_i   (char_code_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .width_value_i (width_value_i),
    .start_char_i  (cfg_q.start_char),
    .head_o        (head),
    .head_valid_o  (head_valid),
    .head_pop_i    (head_pop)
  );

  bfgl_back #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop)
  );

  assign empty          = !res_valid;
  assign quad_valid_o   = res.quad_valid;
  assign left_x_o       = res.left_x;
  assign top_y_o        = res.top_y;
  assign right_x_o      = res.right_x;
  assign bottom_y_o     = res.bottom_y;
  assign tex_left_o     = res.tex_left;
  assign tex_top_o      = res.tex_top;
  assign tex_right_o    = res.tex_right;
  assign tex_bottom_o   = res.tex_bottom;
  assign cursor_x_out_o = res.cursor_x;
  assign cursor_y_out_o = res.cursor_y;

endmodule

### test/tb_bitmap_font_glyph_layout.sv
`timescale 1ns / 1ps

module tb_bitmap_font_glyph_layout;
  import bfgl_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int SCRIPT_LEN = 23;
  localparam int SETTLE_CYCLES = 15;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  code;
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  wv;
  } glyph_item_t;

  // Rows with typed set carry a hand-written cursor; their quad fields are zero.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  code;
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  wv;
    logic        typed;
    logic [15:0] ex_x;
    logic [15:0] ex_y;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] operation_i = '0;
  logic [7:0] char_code_i = '0;
  logic signed [15:0] pos_x_i = '0;
  logic signed [15:0] pos_y_i = '0;
  logic [7:0] width_value_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic quad_valid_o;
  logic signed [15:0] left_x_o;
  logic signed [15:0] top_y_o;
  logic signed [15:0] right_x_o;
  logic signed [15:0] bottom_y_o;
  logic [15:0] tex_left_o;
  logic [15:0] tex_top_o;
  logic [15:0] tex_right_o;
  logic [15:0] tex_bottom_o;
  logic signed [15:0] cursor_x_out_o;
  logic signed [15:0] cursor_y_out_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Layout state mirrored by the testbench
  logic [7:0]  start_code = 8'd32;
  logic [8:0]  glyph_cols = 9'd16;
  logic [7:0]  cell_w = 8'd16;
  logic [7:0]  cell_h = 8'd16;
  logic [7:0]  font_h = 8'd16;
  logic [15:0] cur_x = '0;
  logic [15:0] cur_y = '0;
  logic [15:0] line_x = '0;
  logic [7:0]  width_mem [256];
  bit          width_known [256];

  res_t pending_layouts [$];
  int   mismatches = 0;
  bit   steady = 1'b0;
  bit   pressure_req = 1'b0;
  int   gap_pct = 20;

  script_row_t script [SCRIPT_LEN] = '{
    '{OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'h0000, 16'h0000},
    '{OP_BEGIN, 8'h00, 16'h7FFF, 16'h8000, 8'h00, 1'b1, 16'h7FFF, 16'h8000},
    '{OP_LOAD, 8'd65, 16'h0000, 16'h0000, 8'hFF, 1'b1, 16'h7FFF, 16'h8000},
    '{OP_LOAD, 8'h00, 16'hFFFF, 16'hFFFF, 8'h00, 1'b1, 16'h7FFF, 16'h8000},
    '{OP_LOAD, 8'hFF, 16'h0000, 16'h0000, 8'h08, 1'b1, 16'h7FFF, 16'h8000},
    '{OP_LOAD, 8'd32, 16'h0000, 16'h0000, 8'h07, 1'b1, 16'h7FFF, 16'h8000},
    '{OP_LOAD, NEWLINE_CODE, 16'h0000, 16'h0000, 8'hC8, 1'b1, 16'h7FFF, 16'h8000},
    '{OP_LOAD, 8'hAA, 16'h5555, 16'hAAAA, 8'h55, 1'b1, 16'h7FFF, 16'h8000},
    '{OP_LOAD, 8'h55, 16'hAAAA, 16'h5555, 8'hAA, 1'b1, 16'h7FFF, 16'h8000},
    '{OP_DRAW, 8'd65, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 8'hFF, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, NEWLINE_CODE, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 8'd32, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{OP_BEGIN, 8'hFF, 16'h8000, 16'h7FFF, 8'hFF, 1'b1, 16'h8000, 16'h7FFF},
    '{OP_DRAW, 8'hAA, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, 8'h55, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, NEWLINE_CODE, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{OP_UNUSED, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{OP_BEGIN, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 16'h0000, 16'h0000},
    '{OP_LOAD, 8'd31, 16'h0000, 16'h0000, 8'h03, 1'b1, 16'h0000, 16'h0000},
    '{OP_DRAW, 8'd31, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000},
    '{OP_DRAW, NEWLINE_CODE, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000}
  };

  bitmap_font_glyph_layout i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] sat_texel(input logic [16:0] v);
    return (v > 17'h0FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // Advance the mirrored state by one item and return the layout it yields.
  function automatic res_t layout_step(input glyph_item_t it);
    res_t r;
    logic [8:0] cols;
    logic [7:0] slot;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] w;
    logic [16:0] tl;
    logic [16:0] tt;
    r = '0;
    case (it.op)
      OP_BEGIN: begin
        cur_x = it.px;
        cur_y = it.py;
        line_x = it.px;
      end
      OP_LOAD: width_mem[it.code] = it.wv;
      OP_DRAW: begin
        if (it.code == NEWLINE_CODE) begin
          cur_y = cur_y + {8'd0, font_h};
          cur_x = line_x;
        end else begin
          cols = (glyph_cols == 9'd0) ? 9'd1 : (glyph_cols > 9'd256) ? 9'd256 : glyph_cols;
          slot = it.code - start_code;
          row = 8'({1'b0, slot} / cols);
          col = 8'({1'b0, slot} % cols);
          w = width_mem[it.code];
          tl = 17'(col) * 17'(cell_w);
          tt = 17'(row) * 17'(cell_h);
          r.quad_valid = 1'b1;
          r.left_x = cur_x;
          r.top_y = cur_y;
          r.right_x = cur_x + {8'd0, w};
          r.bottom_y = cur_y + {8'd0, cell_h};
          r.tex_left = sat_texel(tl);
          r.tex_top = sat_texel(tt);
          r.tex_right = sat_texel(tl + 17'(w));
          r.tex_bottom = sat_texel(tt + 17'(cell_h));
          cur_x = cur_x + {8'd0, w};
        end
      end
      default: ;
    endcase
    r.cursor_x = cur_x;
    r.cursor_y = cur_y;
    return r;
  endfunction

  function automatic logic [15:0] corner_coord();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Mostly text: glyph runs with newlines and restarts; a draw of a code with no
  // width yet becomes the load of that width.
  function automatic glyph_item_t random_item();
    glyph_item_t it;
    int pick;
    it.op = OP_DRAW;
    it.code = 8'($urandom);
    it.px = 16'($urandom);
    it.py = 16'($urandom);
    it.wv = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.op = OP_BEGIN;
      if ($urandom_range(0, 3) == 0) begin
        it.px = corner_coord();
        it.py = corner_coord();
      end
    end else if (pick < 18) begin
      it.op = OP_LOAD;
    end else if (pick < 25) begin
      it.code = NEWLINE_CODE;
    end else if (pick < 28) begin
      it.op = OP_UNUSED;
    end
    if (it.op == OP_DRAW && it.code != NEWLINE_CODE && !width_known[it.code])
      it.op = OP_LOAD;
    if (it.op == OP_LOAD)
      width_known[it.code] = 1'b1;
    return it;
  endfunction

  task automatic send_item(input glyph_item_t it, input logic typed, input res_t want);
    res_t predicted;
    push <= 1'b1;
    operation_i <= it.op;
    char_code_i <= it.code;
    pos_x_i <= it.px;
    pos_y_i <= it.py;
    width_value_i <= it.wv;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predicted = layout_step(it);
    pending_layouts.push_back(typed ? want : predicted);
  endtask

  task automatic sender_gap();
    int n;
    if (!steady && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 19);
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] value);
    logic [31:0] word;
    word = $urandom;
    word[8:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_START_CHAR:    start_code = word[7:0];
      REG_GLYPH_COLUMNS: glyph_cols = word[8:0];
      REG_CELL_WIDTH:    cell_w = word[7:0];
      REG_CELL_HEIGHT:   cell_h = word[7:0];
      REG_FONT_HEIGHT:   font_h = word[7:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_layouts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    res_t want;
    if (pending_layouts.size() == 0) begin
      $error("result transfer with no item pending");
      mismatches++;
    end else begin
      want = pending_layouts.pop_front();
      check_field("quad_valid", 16'(want.quad_valid), 16'(quad_valid_o));
      check_field("left_x", want.left_x, left_x_o);
      check_field("top_y", want.top_y, top_y_o);
      check_field("right_x", want.right_x, right_x_o);
      check_field("bottom_y", want.bottom_y, bottom_y_o);
      check_field("tex_left", want.tex_left, tex_left_o);
      check_field("tex_top", want.tex_top, tex_top_o);
      check_field("tex_right", want.tex_right, tex_right_o);
      check_field("tex_bottom", want.tex_bottom, tex_bottom_o);
      check_field("cursor_x_out", want.cursor_x, cursor_x_out_o);
      check_field("cursor_y_out", want.cursor_y, cursor_y_out_o);
    end
  endtask

  // Result side: random pop stalls, plus one long hold when asked.
  initial begin
    int hold;
    int pct;
    int tick;
    hold = 0;
    pct = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_result();
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold = 400;
      end
      tick++;
      if (tick % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: pct = 0;
          1: pct = 5;
          default: pct = 25;
        endcase
      end
      if (hold == 0 && !steady && $urandom_range(0, 99) < pct)
        hold = $urandom_range(1, 19);
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    glyph_item_t it;
    res_t want;
    logic [8:0] regs [5];
    for (int i = 0; i < 256; i++) width_mem[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      it = '{script[i].op, script[i].code, script[i].px, script[i].py, script[i].wv};
      if (it.op == OP_LOAD) width_known[it.code] = 1'b1;
      want = '0;
      want.cursor_x = script[i].ex_x;
      want.cursor_y = script[i].ex_y;
      send_item(it, script[i].typed, want);
      sender_gap();
    end
    push <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: regs = '{9'd32, 9'd16, 9'd16, 9'd16, 9'd16};
        1: regs = '{9'd0, 9'd256, 9'd255, 9'd255, 9'd255};
        2: regs = '{9'd255, 9'd1, 9'd1, 9'd1, 9'd0};
        3: regs = '{9'd7, 9'd0, 9'd8, 9'd8, 9'd8};
        4: regs = '{9'd128, 9'd511, 9'd255, 9'd1, 9'd255};
        default: regs = '{9'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                          9'($urandom_range(0, 255)), 9'($urandom_range(0, 255)),
                          9'($urandom_range(0, 255))};
      endcase
      write_reg(REG_START_CHAR, regs[0]);
      write_reg(REG_GLYPH_COLUMNS, regs[1]);
      write_reg(REG_CELL_WIDTH, regs[2]);
      write_reg(REG_CELL_HEIGHT, regs[3]);
      write_reg(REG_FONT_HEIGHT, regs[4]);
      gap_pct = (p % 3 == 0) ? 0 : 20;
      // fill the block against a stalled result side
      if (p == 1) pressure_req = 1'b1;
      if (p == PHASES - 1) steady = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        send_item(random_item(), 1'b0, '0);
        sender_gap();
      end
      push <= 1'b0;
    end

    drain();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
